@@ hw/rtl/sq_pkg.sv @@
`timescale 1ns / 1ps

package sq_pkg;

    localparam int DEPTH       = 8;
    localparam int MAX_RESULTS = 8;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int HIT_W       = $clog2(MAX_RESULTS + 1);
    localparam int WALK_CAP    = (MAX_RESULTS < DEPTH) ? MAX_RESULTS : DEPTH;

    localparam logic [2:0] MODE_DUMP   = 3'd0;
    localparam logic [2:0] MODE_PUSH   = 3'd1;
    localparam logic [2:0] MODE_POP    = 3'd2;
    localparam logic [2:0] MODE_SEARCH = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } sq_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         position;
        logic signed [31:0] entry;
        logic               last;
    } sq_out_t;

    typedef struct packed {
        logic walk_start;
        logic walk_search;
        logic walk_step;
        logic pop_issue;
        logic pop_finish;
        logic push;
        logic clear;
        logic emit_full;
        logic emit_empty;
        logic flush;
    } sq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic walk_end;
    } sq_stat_t;

    // ring pointer plus offset, offset at most DEPTH
    function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [CNT_W:0] total;
        total = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (total >= (CNT_W + 1)'(DEPTH))
        begin
            total = total - (CNT_W + 1)'(DEPTH);
        end
        return total[PTR_W-1:0];
    endfunction

    function automatic logic [2:0] to_pos(logic [CNT_W-1:0] idx);
        logic [CNT_W+2:0] wide;
        wide = (CNT_W + 3)'(idx);
        return wide[2:0];
    endfunction

endpackage

@@ hw/rtl/sq_ram.sv @@
`timescale 1ns / 1ps

module sq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/sq_ctrl.sv @@
`timescale 1ns / 1ps

module sq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sq_pkg::sq_in_t    item,
    input  sq_pkg::sq_stat_t  stat,
    output logic              busy,
    output sq_pkg::sq_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_POP   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       search_reg, search_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        search_next = search_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (item.mode)
                        sq_pkg::MODE_DUMP, sq_pkg::MODE_SEARCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.walk_start  = 1'b1;
                                cmd.walk_search = (item.mode == sq_pkg::MODE_SEARCH);
                                search_next     = (item.mode == sq_pkg::MODE_SEARCH);
                                state_next      = S_WALK;
                            end
                        end
                        sq_pkg::MODE_PUSH:
                        begin
                            if (stat.full)
                            begin
                                cmd.emit_full = 1'b1;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                        sq_pkg::MODE_POP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_issue = 1'b1;
                                state_next    = S_POP;
                            end
                        end
                        sq_pkg::MODE_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = search_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_POP:
            begin
                cmd.pop_finish = 1'b1;
                state_next     = S_IDLE;
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            search_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            search_reg <= search_next;
        end
    end

endmodule

@@ hw/rtl/sq_datapath.sv @@
`timescale 1ns / 1ps

module sq_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sq_pkg::sq_cmd_t   cmd,
    input  sq_pkg::sq_in_t    item,
    output sq_pkg::sq_stat_t  stat,
    output logic              strobe,
    output sq_pkg::sq_out_t   result
);

    localparam int PW = sq_pkg::PTR_W;
    localparam int CW = sq_pkg::CNT_W;
    localparam int HW = sq_pkg::HIT_W;

    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [CW-1:0]      proc_reg, proc_next;
    logic               rvalid_reg, rvalid_next;
    logic               search_reg, search_next;
    logic signed [31:0] key_reg, key_next;
    logic [HW-1:0]      hits_reg, hits_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [2:0]         pend_pos_reg, pend_pos_next;
    logic signed [31:0] pend_entry_reg, pend_entry_next;
    logic               res_valid_reg, res_valid_next;
    sq_pkg::sq_out_t    res_reg, res_next;

    logic               ram_we;
    logic [PW-1:0]      ram_waddr;
    logic [PW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] rd_entry;
    logic [CW-1:0]      lim;
    logic               hit;
    logic               hit_cap;

    sq_ram #(
        .WIDTH (32),
        .DEPTH (sq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign ram_we    = cmd.push;
    assign ram_waddr = sq_pkg::ring_add(head_reg, count_reg);
    assign ram_raddr = (cmd.walk_start || cmd.pop_issue) ? head_reg
                                                        : sq_pkg::ring_add(head_reg, iss_reg);

    // dump reports at most the result cap, search scans every entry until the hit cap
    assign lim = (search_reg || count_reg <= CW'(sq_pkg::WALK_CAP)) ? count_reg
                                                                    : CW'(sq_pkg::WALK_CAP);
    assign hit     = search_reg && (rd_entry == key_reg);
    assign hit_cap = hit && (hits_reg == HW'(sq_pkg::MAX_RESULTS - 1));

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(sq_pkg::DEPTH));
    assign stat.walk_end = rvalid_reg && ((proc_reg == lim - CW'(1)) || hit_cap);

    assign strobe = res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        iss_next        = iss_reg;
        proc_next       = proc_reg;
        rvalid_next     = 1'b0;
        search_next     = search_reg;
        key_next        = key_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_entry_next = pend_entry_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;

        if (cmd.emit_empty)
        begin
            res_valid_next = 1'b1;
            res_next       = '{sq_pkg::ST_EMPTY, 3'd0, 32'sd0, 1'b1};
        end
        if (cmd.emit_full)
        begin
            res_valid_next = 1'b1;
            res_next       = '{sq_pkg::ST_FULL, 3'd0, 32'sd0, 1'b1};
        end
        if (cmd.clear)
        begin
            count_next     = '0;
            head_next      = '0;
            res_valid_next = 1'b1;
            res_next       = '{sq_pkg::ST_OK, 3'd0, 32'sd0, 1'b1};
        end
        if (cmd.push)
        begin
            count_next     = count_reg + CW'(1);
            res_valid_next = 1'b1;
            res_next       = '{sq_pkg::ST_OK, sq_pkg::to_pos(count_reg), item.value, 1'b1};
        end
        if (cmd.pop_finish)
        begin
            count_next     = count_reg - CW'(1);
            head_next      = sq_pkg::ring_add(head_reg, CW'(1));
            res_valid_next = 1'b1;
            res_next       = '{sq_pkg::ST_OK, 3'd0, rd_entry, 1'b1};
        end
        if (cmd.walk_start)
        begin
            search_next     = cmd.walk_search;
            key_next        = item.value;
            iss_next        = CW'(1);
            proc_next       = '0;
            rvalid_next     = 1'b1;
            hits_next       = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.walk_step)
        begin
            if (iss_reg < lim)
            begin
                iss_next    = iss_reg + CW'(1);
                rvalid_next = 1'b1;
            end
            if (rvalid_reg)
            begin
                proc_next = proc_reg + CW'(1);
                if (!search_reg)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{sq_pkg::ST_OK, sq_pkg::to_pos(proc_reg), rd_entry,
                                       stat.walk_end};
                end
                else if (hit)
                begin
                    // a match is held back until the next one shows it was not the last
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{sq_pkg::ST_OK, pend_pos_reg, pend_entry_reg, 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_pos_next   = sq_pkg::to_pos(proc_reg);
                    pend_entry_next = rd_entry;
                    hits_next       = hits_reg + HW'(1);
                end
            end
        end
        if (cmd.flush)
        begin
            res_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                res_next = '{sq_pkg::ST_OK, pend_pos_reg, pend_entry_reg, 1'b1};
            end
            else
            begin
                res_next = '{sq_pkg::ST_NOTFOUND, 3'd0, 32'sd0, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            head_reg       <= '0;
            iss_reg        <= '0;
            proc_reg       <= '0;
            rvalid_reg     <= 1'b0;
            search_reg     <= 1'b0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            iss_reg        <= iss_next;
            proc_reg       <= proc_next;
            rvalid_reg     <= rvalid_next;
            search_reg     <= search_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        pend_pos_reg   <= pend_pos_next;
        pend_entry_reg <= pend_entry_next;
        res_reg        <= res_next;
    end

endmodule

@@ hw/rtl/search_queue_top.sv @@
`timescale 1ns / 1ps
// Bounded FIFO of signed 32-bit words with a linear search.
// Command channel: item (mode, value) is taken on a rising edge with start high
// and busy low. Modes: dump, push, pop, search, clear; unused modes are taken
// and dropped without a result.
// Result channel: strobe marks result (status, position, entry, last) for one
// cycle; the receiver cannot stall, so every result must be taken as shown.
// last is set on the final result of each command.
// Timing: push, clear and the full/empty replies appear the cycle after the
// transfer; a pop reads the RAM and replies from the S_POP state. Dump and
// search read the ring buffer RAM one entry per cycle through its single
// registered read port: dump results follow the RAM read, one per cycle; a
// search match is reported one match later, the final one after a flush state.
// Throughput: push and clear every cycle; pop, dump and search hold busy
// high through their states, so no new command is taken until they end.
// A new command may be taken while a result is on the result ports.
// Reset empties the queue; entry storage is not cleared and needs no sweep.

module search_queue_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sq_pkg::sq_in_t   item,
    output logic             strobe,
    output sq_pkg::sq_out_t  result
);

    sq_pkg::sq_cmd_t  cmd;
    sq_pkg::sq_stat_t stat;

    sq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    sq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.status != sq_pkg::ST_OK) |-> result.last)
        else $error("error status without last");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.status != sq_pkg::ST_OK)
            |-> (result.position == 3'd0) && (result.entry == 32'sd0))
        else $error("error result carries data");

    a_push_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.mode == sq_pkg::MODE_PUSH) |=> strobe && result.last)
        else $error("push gave no reply");

    a_clear_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.mode == sq_pkg::MODE_CLEAR)
            |=> strobe && (result.status == sq_pkg::ST_OK) && !busy)
        else $error("clear reply missing");

endmodule

@@ tb/sv/search_queue_top_tb.sv @@
`timescale 1ns / 1ps

module search_queue_top_tb;

    // modes the block takes and drops without a reply
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_CMDS = 180;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        sq_pkg::sq_in_t  cmd;
        logic            fixed;
        sq_pkg::sq_out_t reply;
    } cmd_row_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    sq_pkg::sq_in_t  item;
    logic            strobe;
    sq_pkg::sq_out_t result;

    // shadow copy of the queue contents
    int                 shadow_count;
    logic signed [31:0] shadow_entries [sq_pkg::DEPTH];

    sq_pkg::sq_out_t queue_replies [$];
    cmd_row_t        directed_rows [$];
    logic signed [31:0] key_pool [4];

    int mismatches;
    int quiet_left;
    bit no_idle;
    bit filling;

    search_queue_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("search_queue_top verification failed");
        $finish;
    end

    function automatic void add_reply(input logic [1:0] status, input int pos,
                                      input logic signed [31:0] entry);
        sq_pkg::sq_out_t r;
        r.status   = status;
        r.position = 3'(pos);
        r.entry    = entry;
        r.last     = 1'b0;
        queue_replies.push_back(r);
    endfunction

    // updates the shadow queue and returns how many replies were appended
    function automatic int apply_queue_cmd(input sq_pkg::sq_in_t cmd);
        sq_pkg::sq_out_t r;
        logic signed [31:0] head;
        int n;
        n = 0;
        case (cmd.mode)
            sq_pkg::MODE_DUMP:
            begin
                if (shadow_count == 0)
                begin
                    add_reply(sq_pkg::ST_EMPTY, 0, '0);
                    n++;
                end
                else
                begin
                    for (int i = 0; i < shadow_count && n < sq_pkg::MAX_RESULTS; i++)
                    begin
                        add_reply(sq_pkg::ST_OK, i, shadow_entries[i]);
                        n++;
                    end
                end
            end
            sq_pkg::MODE_PUSH:
            begin
                if (shadow_count >= sq_pkg::DEPTH)
                begin
                    add_reply(sq_pkg::ST_FULL, 0, '0);
                end
                else
                begin
                    shadow_entries[shadow_count] = cmd.value;
                    add_reply(sq_pkg::ST_OK, shadow_count, cmd.value);
                    shadow_count++;
                end
                n++;
            end
            sq_pkg::MODE_POP:
            begin
                if (shadow_count == 0)
                begin
                    add_reply(sq_pkg::ST_EMPTY, 0, '0);
                end
                else
                begin
                    head = shadow_entries[0];
                    for (int i = 0; i + 1 < shadow_count; i++)
                    begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                    add_reply(sq_pkg::ST_OK, 0, head);
                end
                n++;
            end
            sq_pkg::MODE_SEARCH:
            begin
                if (shadow_count == 0)
                begin
                    add_reply(sq_pkg::ST_EMPTY, 0, '0);
                    n++;
                end
                else
                begin
                    for (int i = 0; i < shadow_count && n < sq_pkg::MAX_RESULTS; i++)
                    begin
                        if (shadow_entries[i] == cmd.value)
                        begin
                            add_reply(sq_pkg::ST_OK, i, shadow_entries[i]);
                            n++;
                        end
                    end
                    if (n == 0)
                    begin
                        add_reply(sq_pkg::ST_NOTFOUND, 0, '0);
                        n++;
                    end
                end
            end
            sq_pkg::MODE_CLEAR:
            begin
                shadow_count = 0;
                add_reply(sq_pkg::ST_OK, 0, '0);
                n++;
            end
            default:
            begin
            end
        endcase
        if (n > 0)
        begin
            r = queue_replies.pop_back();
            r.last = 1'b1;
            queue_replies.push_back(r);
        end
        return n;
    endfunction

    function automatic void add_row(input logic [2:0] mode, input logic signed [31:0] value,
                                    input logic fixed, input logic [1:0] status,
                                    input int pos, input logic signed [31:0] entry);
        cmd_row_t row;
        row.cmd.mode        = mode;
        row.cmd.value       = value;
        row.fixed           = fixed;
        row.reply.status    = status;
        row.reply.position  = 3'(pos);
        row.reply.entry     = entry;
        row.reply.last      = 1'b1;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left == 0)
        begin
            quiet_left = $urandom_range(10, 30);
            no_idle = ($urandom_range(0, 3) == 0);
        end
        quiet_left--;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return key_pool[$urandom_range(0, 3)];
        else if (r < 6 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        else if (r < 7)
        begin
            case ($urandom_range(0, 3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        else
            return $urandom;
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (filling && shadow_count == sq_pkg::DEPTH && $urandom_range(0, 5) == 0)
            filling = 1'b0;
        else if (!filling && shadow_count == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
        if (r < 4)
        begin
            case ($urandom_range(0, 2))
                0:       return MODE_SPARE5;
                1:       return MODE_SPARE6;
                default: return MODE_SPARE7;
            endcase
        end
        else if (r < 7)
            return sq_pkg::MODE_CLEAR;
        else if (r < 27)
            return sq_pkg::MODE_SEARCH;
        else if (r < 42)
            return sq_pkg::MODE_DUMP;
        else if (filling)
            return (r < 85) ? sq_pkg::MODE_PUSH : sq_pkg::MODE_POP;
        else
            return (r < 57) ? sq_pkg::MODE_PUSH : sq_pkg::MODE_POP;
    endfunction

    // holds start until the transfer, then predicts the replies and lowers start for a nonzero gap
    task automatic send_cmd(input sq_pkg::sq_in_t cmd, input int gap, input logic fixed,
                            input sq_pkg::sq_out_t fixed_reply);
        int n;
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = apply_queue_cmd(cmd);
        if (fixed)
        begin
            repeat (n) void'(queue_replies.pop_back());
            queue_replies.push_back(fixed_reply);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        sq_pkg::sq_out_t want;
        if (rst_n && strobe)
        begin
            if (queue_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: status=%0d pos=%0d entry=%0d last=%0d",
                             result.status, result.position, result.entry, result.last);
            end
            else
            begin
                want = queue_replies.pop_front();
                if (result.status !== want.status || result.position !== want.position ||
                    result.entry !== want.entry || result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"reply mismatch: expected status=%0d pos=%0d entry=%0d ",
                                  "last=%0d, got status=%0d pos=%0d entry=%0d last=%0d"},
                                 want.status, want.position, want.entry, want.last,
                                 result.status, result.position, result.entry,
                                 result.last);
                end
            end
        end
    end

    initial
    begin
        sq_pkg::sq_in_t  cmd;
        sq_pkg::sq_out_t none;
        int              counted;

        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        none         = '0;
        mismatches   = 0;
        shadow_count = 0;
        quiet_left   = 0;
        no_idle      = 1'b0;
        filling      = 1'b1;
        counted      = 0;
        for (int i = 0; i < sq_pkg::DEPTH; i++)
            shadow_entries[i] = '0;
        for (int i = 0; i < 4; i++)
            key_pool[i] = $urandom;

        // empty queue replies, spare modes, extremes, full queue, multi-hit search
        add_row(sq_pkg::MODE_DUMP,   '0,       1'b1, sq_pkg::ST_EMPTY,    0, '0);
        add_row(sq_pkg::MODE_POP,    '0,       1'b1, sq_pkg::ST_EMPTY,    0, '0);
        add_row(sq_pkg::MODE_SEARCH, WORD_MAX, 1'b1, sq_pkg::ST_EMPTY,    0, '0);
        add_row(MODE_SPARE5,         -32'sd1,  1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(MODE_SPARE7,         WORD_MIN, 1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   WORD_MIN, 1'b1, sq_pkg::ST_OK,       0, WORD_MIN);
        add_row(sq_pkg::MODE_PUSH,   WORD_MAX, 1'b1, sq_pkg::ST_OK,       1, WORD_MAX);
        add_row(sq_pkg::MODE_PUSH,   '0,       1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   -32'sd1,  1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   WORD_MAX, 1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   32'sh5555_5555, 1'b0, sq_pkg::ST_OK, 0, '0);
        add_row(sq_pkg::MODE_PUSH,   32'shaaaa_aaaa, 1'b0, sq_pkg::ST_OK, 0, '0);
        add_row(sq_pkg::MODE_PUSH,   -32'sd1,  1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   32'sd5,   1'b1, sq_pkg::ST_FULL,     0, '0);
        add_row(sq_pkg::MODE_DUMP,   '0,       1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_SEARCH, WORD_MAX, 1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_SEARCH, -32'sd1,  1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_SEARCH, 32'sd12345, 1'b1, sq_pkg::ST_NOTFOUND, 0, '0);
        add_row(sq_pkg::MODE_POP,    '0,       1'b1, sq_pkg::ST_OK,       0, WORD_MIN);
        add_row(sq_pkg::MODE_DUMP,   '0,       1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_PUSH,   32'sd3,   1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_SEARCH, 32'sd3,   1'b0, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_CLEAR,  WORD_MAX, 1'b1, sq_pkg::ST_OK,       0, '0);
        add_row(sq_pkg::MODE_DUMP,   '0,       1'b1, sq_pkg::ST_EMPTY,    0, '0);
        add_row(MODE_SPARE6,         32'sd7,   1'b0, sq_pkg::ST_OK,       0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, pick_gap(), directed_rows[i].fixed,
                     directed_rows[i].reply);

        while (counted < RANDOM_CMDS)
        begin
            cmd.mode  = pick_mode();
            cmd.value = pick_value();
            if (cmd.mode <= sq_pkg::MODE_CLEAR)
                counted++;
            send_cmd(cmd, pick_gap(), 1'b0, none);
        end

        start <= 1'b0;
        while (queue_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (queue_replies.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("search_queue_top verification clean");
        else
            $display("search_queue_top verification failed");
        $finish;
    end

endmodule
